FILE: src/kwhm_pkg.sv
package kwhm_pkg;

  localparam int MAX_WAYS      = 64;
  localparam int KEY_BITS      = 64;
  localparam int WAY_BITS      = $clog2(MAX_WAYS);
  localparam int CNT_BITS      = WAY_BITS + 1;
  // child index of the deepest node can reach 2*MAX_WAYS
  localparam int IDX_BITS      = WAY_BITS + 2;
  localparam int ADDR_BITS     = 3;
  localparam int IN_USER_BITS  = 2;
  localparam int OUT_DATA_BITS = 72;
  localparam int PAD_BITS      = OUT_DATA_BITS - WAY_BITS - KEY_BITS;

  // register index, taken from paddr[2]
  localparam logic REG_WAYS_IN_USE = 1'b0;

  localparam logic [CNT_BITS-1:0] WAYS_RESET = CNT_BITS'(64);

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_REPLACE = 1'b1;

  typedef struct packed {
    logic                exh;
    logic [WAY_BITS-1:0] way;
    logic [KEY_BITS-1:0] key;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUILD,
    ST_LOAD_CUR,
    ST_SIFT_RD,
    ST_SIFT_CMP,
    ST_EMIT
  } state_e;

  // exhausted entries sort above every key, two exhausted entries compare equal
  function automatic logic entry_less(entry_t a, entry_t b);
    logic res;
    if (a.exh) begin
      res = 1'b0;
    end else if (b.exh) begin
      res = 1'b1;
    end else begin
      res = (a.key < b.key);
    end
    return res;
  endfunction

endpackage

FILE: src/k_way_heap_merge.sv
// k-way merge on a binary min-heap of up to 64 ways. Load transactions (tuser[0] = 0) bring
// the head key of way 0, 1, 2 and so on; loading ends after ways_in_use heads or at the
// first load that flags an empty way (tuser[1]). The heap is then built bottom-up and the
// smallest key is sent with its way; every replace transaction (tuser[0] = 1) gives the
// next key of that way, or marks it exhausted, and answers with the next minimum, or with
// done once all ways are exhausted. The heap sits in two copies of a 64-entry RAM so that
// both children of a node are read at once; each heap level is a child read, then a
// compare and write back. No clearing pass is needed after reset.
module k_way_heap_merge (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [kwhm_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // key
  input  logic [kwhm_pkg::KEY_BITS-1:0]       s_axis_tdata,
  // func, stream_empty
  input  logic [kwhm_pkg::IN_USER_BITS-1:0]   s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // min_key, min_way, zero padding
  output logic [kwhm_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
  // done_res
  output logic [0:0]                          m_axis_tuser
);

  import kwhm_pkg::*;

  state_e state_q, state_d;

  logic [CNT_BITS-1:0] ways_q;
  logic [CNT_BITS-1:0] count_q, count_d;
  logic [CNT_BITS-1:0] exh_q, exh_d;
  logic                merging_q, merging_d;
  logic                sift_build_q, sift_build_d;
  logic [WAY_BITS-1:0] build_n_q, build_n_d;
  logic [WAY_BITS-1:0] node_q, node_d;
  entry_t              cur_q, cur_d;
  entry_t              root_q, root_d;
  logic                out_valid_q, out_valid_d;
  logic [KEY_BITS-1:0] out_key_q, out_key_d;
  logic [WAY_BITS-1:0] out_way_q, out_way_d;
  logic                out_done_q, out_done_d;

  logic                ram_we;
  logic [WAY_BITS-1:0] ram_waddr;
  entry_t              ram_wdata;
  logic [WAY_BITS-1:0] raddr_a, raddr_b;
  entry_t              rdata_a, rdata_b;

  logic                in_fire, func, empty;
  logic [CNT_BITS-1:0] limit, new_count;
  logic                stored, load_last, all_done, cfg_write;
  logic [IDX_BITS-1:0] left_idx, right_idx;
  logic                left_ok, right_ok, l_lt_c, r_lt_c, r_lt_l;
  logic                pick_left, pick_right, emit_fire;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[ADDR_BITS-1] == REG_WAYS_IN_USE);
  assign prdata    = (paddr[ADDR_BITS-1] == REG_WAYS_IN_USE) ?
                     {{(32-CNT_BITS){1'b0}}, ways_q} : 32'd0;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign func          = s_axis_tuser[0];
  assign empty         = s_axis_tuser[1];

  always_comb begin
    if (ways_q == '0) begin
      limit = CNT_BITS'(1);
    end else if (ways_q > CNT_BITS'(MAX_WAYS)) begin
      limit = CNT_BITS'(MAX_WAYS);
    end else begin
      limit = ways_q;
    end
  end

  assign stored    = !empty && (count_q < CNT_BITS'(MAX_WAYS));
  assign new_count = count_q + CNT_BITS'(stored);
  assign load_last = empty || (new_count >= limit) || (new_count >= CNT_BITS'(MAX_WAYS));
  assign all_done  = (exh_q >= count_q);

  // child compare of one sift level
  assign left_idx   = {1'b0, node_q, 1'b1};
  assign right_idx  = left_idx + IDX_BITS'(1);
  assign left_ok    = left_idx < IDX_BITS'(count_q);
  assign right_ok   = right_idx < IDX_BITS'(count_q);
  assign l_lt_c     = left_ok && entry_less(rdata_a, cur_q);
  assign r_lt_c     = right_ok && entry_less(rdata_b, cur_q);
  assign r_lt_l     = right_ok && entry_less(rdata_b, rdata_a);
  assign pick_left  = l_lt_c && !r_lt_l;
  assign pick_right = l_lt_c ? r_lt_l : r_lt_c;

  assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (!merging_q) begin
            if (func == FUNC_LOAD && load_last) begin
              state_d = ST_BUILD;
            end
          end else if (func == FUNC_REPLACE) begin
            state_d = all_done ? ST_EMIT : ST_SIFT_RD;
          end
        end
      end
      ST_BUILD:    state_d = (build_n_q == '0) ? ST_EMIT : ST_LOAD_CUR;
      ST_LOAD_CUR: state_d = ST_SIFT_RD;
      ST_SIFT_RD:  state_d = ST_SIFT_CMP;
      ST_SIFT_CMP: begin
        if (!pick_left && !pick_right) begin
          state_d = sift_build_q ? ST_BUILD : ST_EMIT;
        end else begin
          state_d = ST_SIFT_RD;
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_d      = count_q;
    exh_d        = exh_q;
    merging_d    = merging_q;
    sift_build_d = sift_build_q;
    build_n_d    = build_n_q;
    node_d       = node_q;
    cur_d        = cur_q;
    out_valid_d  = out_valid_q;
    out_key_d    = out_key_q;
    out_way_d    = out_way_q;
    out_done_d   = out_done_q;
    ram_we       = 1'b0;
    ram_waddr    = node_q;
    ram_wdata    = cur_q;
    raddr_a      = left_idx[WAY_BITS-1:0];
    raddr_b      = right_idx[WAY_BITS-1:0];

    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (!merging_q) begin
            if (func == FUNC_LOAD) begin
              if (stored) begin
                ram_we    = 1'b1;
                ram_waddr = count_q[WAY_BITS-1:0];
                ram_wdata = '{exh: 1'b0, way: count_q[WAY_BITS-1:0], key: s_axis_tdata};
              end
              count_d = new_count;
              if (load_last) begin
                merging_d    = 1'b1;
                sift_build_d = 1'b1;
                build_n_d    = new_count[CNT_BITS-1:1];
              end
            end
          end else if (func == FUNC_REPLACE && !all_done) begin
            sift_build_d = 1'b0;
            node_d       = '0;
            cur_d        = root_q;
            if (empty) begin
              cur_d.exh = 1'b1;
              exh_d     = exh_q + CNT_BITS'(1);
            end else begin
              cur_d.key = s_axis_tdata;
            end
          end
        end
      end
      ST_BUILD: begin
        if (build_n_q != '0) begin
          build_n_d = build_n_q - WAY_BITS'(1);
          node_d    = build_n_q - WAY_BITS'(1);
          raddr_a   = build_n_q - WAY_BITS'(1);
        end
      end
      ST_LOAD_CUR: begin
        cur_d = rdata_a;
      end
      ST_SIFT_RD: begin
      end
      ST_SIFT_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = node_q;
        if (pick_left) begin
          ram_wdata = rdata_a;
          node_d    = left_idx[WAY_BITS-1:0];
        end else if (pick_right) begin
          ram_wdata = rdata_b;
          node_d    = right_idx[WAY_BITS-1:0];
        end else begin
          ram_wdata = cur_q;
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          out_valid_d = 1'b1;
          out_done_d  = all_done;
          out_key_d   = all_done ? '0 : root_q.key;
          out_way_d   = all_done ? '0 : root_q.way;
        end
      end
      default: begin
      end
    endcase
  end

  // copy of heap entry 0, kept in step with every write there
  assign root_d = (ram_we && ram_waddr == '0) ? ram_wdata : root_q;

  kwhm_ram #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(MAX_WAYS)
  ) u_ram_a (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(raddr_a),
    .rdata_o(rdata_a)
  );

  kwhm_ram #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(MAX_WAYS)
  ) u_ram_b (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(raddr_b),
    .rdata_o(rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ways_q       <= WAYS_RESET;
      count_q      <= '0;
      exh_q        <= '0;
      merging_q    <= 1'b0;
      sift_build_q <= 1'b0;
      build_n_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      exh_q        <= exh_d;
      merging_q    <= merging_d;
      sift_build_q <= sift_build_d;
      build_n_q    <= build_n_d;
      out_valid_q  <= out_valid_d;
      if (cfg_write) begin
        ways_q <= pwdata[CNT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    node_q     <= node_d;
    cur_q      <= cur_d;
    root_q     <= root_d;
    out_key_q  <= out_key_d;
    out_way_q  <= out_way_d;
    out_done_q <= out_done_d;
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = {{PAD_BITS{1'b0}}, out_way_q, out_key_q};
  assign m_axis_tuser[0] = out_done_q;

endmodule

FILE: src/kwhm_ram.sv
module kwhm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: bench/tb.sv
module tb;
  import kwhm_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLE = 40;
  localparam int MERGE_ITEMS  = 1360;
  localparam logic [ADDR_BITS-1:0] ADDR_WAYS = {REG_WAYS_IN_USE, 2'b00};
  localparam logic [KEY_BITS-1:0] KEY_ONES = '1;

  typedef struct packed {
    logic                func;
    logic                empty;
    logic [KEY_BITS-1:0] key;
  } way_item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [WAY_BITS-1:0] way;
    logic                done;
  } min_res_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                     psel    = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite  = 1'b0;
  logic [ADDR_BITS-1:0]     paddr   = '0;
  logic [31:0]              pwdata  = '0;
  logic [31:0]              prdata;
  logic                     pready;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [KEY_BITS-1:0]      s_axis_tdata  = '0;
  logic [IN_USER_BITS-1:0]  s_axis_tuser  = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic [0:0]               m_axis_tuser;

  k_way_heap_merge u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  way_item_t way_items_q[$];
  min_res_t  expected_mins_q[$];
  int        items_pushed  = 0;
  int        items_taken   = 0;
  int        mins_seen     = 0;
  int        n_err         = 0;
  int        cycle_cnt     = 0;

  // shadow of the heap and its control state
  entry_t         heap_shadow [MAX_WAYS];
  int             n_entries   = 0;
  int             n_exhausted = 0;
  bit             merging     = 1'b0;
  logic [CNT_BITS-1:0] ways_cfg = WAYS_RESET;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("** k_way_heap_merge: FAILED **");
      $finish;
    end
  end

  function automatic bit heap_lt(int a, int b);
    if (heap_shadow[a].exh) return 1'b0;
    if (heap_shadow[b].exh) return 1'b1;
    return heap_shadow[a].key < heap_shadow[b].key;
  endfunction

  function automatic void sift_heap(int node);
    int     lc;
    int     best;
    entry_t tmp;
    forever begin
      lc   = 2 * node + 1;
      best = node;
      if (lc < n_entries && heap_lt(lc, best)) best = lc;
      if (lc + 1 < n_entries && heap_lt(lc + 1, best)) best = lc + 1;
      if (best == node) return;
      tmp               = heap_shadow[node];
      heap_shadow[node] = heap_shadow[best];
      heap_shadow[best] = tmp;
      node              = best;
    end
  endfunction

  function automatic int way_cap();
    if (ways_cfg == 0) return 1;
    if (ways_cfg > MAX_WAYS) return MAX_WAYS;
    return int'(ways_cfg);
  endfunction

  function automatic void push_min();
    min_res_t r;
    if (n_exhausted >= n_entries) begin
      r = '{key: '0, way: '0, done: 1'b1};
    end else begin
      r = '{key: heap_shadow[0].key, way: heap_shadow[0].way, done: 1'b0};
    end
    expected_mins_q.push_back(r);
  endfunction

  function automatic void heap_step(logic func, logic [KEY_BITS-1:0] key, logic empty);
    int n;
    if (!merging) begin
      if (func != FUNC_LOAD) return;
      if (!empty && n_entries < MAX_WAYS) begin
        heap_shadow[n_entries] = {1'b0, WAY_BITS'(n_entries), key};
        n_entries++;
      end
      if (!empty && n_entries < way_cap() && n_entries < MAX_WAYS) return;
      merging = 1'b1;
      for (n = n_entries - 1; n >= 0; n--) begin
        if (2 * n + 1 < n_entries) sift_heap(n);
      end
      push_min();
      return;
    end
    if (func != FUNC_REPLACE) return;
    if (n_exhausted < n_entries) begin
      if (empty) begin
        heap_shadow[0].exh = 1'b1;
        n_exhausted++;
      end else begin
        heap_shadow[0].key = key;
      end
      sift_heap(0);
    end
    push_min();
  endfunction

  task automatic report_err(string what, logic [KEY_BITS-1:0] got, logic [KEY_BITS-1:0] want);
    $display("mismatch on %s: got %h, expected %h (cycle %0d)", what, got, want, cycle_cnt);
    n_err++;
  endtask

  // sender: offers queued items, pauses about 16% of cycles outside its steady stretch
  always @(posedge clk_i or negedge rst_ni) begin
    way_item_t it;
    bit        pause;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        heap_step(s_axis_tuser[0], s_axis_tdata, s_axis_tuser[1]);
        items_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        pause = !(items_taken >= 600 && items_taken < 800) && ($urandom_range(0, 99) < 16);
        if (way_items_q.size() > 0 && !pause) begin
          it = way_items_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= it.key;
          s_axis_tuser  <= {it.empty, it.func};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off so the input backs up
  int hold_left = 0;
  bit held_once = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (mins_seen >= 300 && !held_once) begin
      held_once     <= 1'b1;
      hold_left     <= 400;
      m_axis_tready <= 1'b0;
    end else if (mins_seen >= 700 && mins_seen < 900) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= 16);
    end
  end

  always @(posedge clk_i) begin
    min_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      mins_seen++;
      if (expected_mins_q.size() == 0) begin
        report_err("unexpected result", m_axis_tdata[KEY_BITS-1:0], '0);
      end else begin
        want = expected_mins_q.pop_front();
        if (m_axis_tdata[KEY_BITS-1:0] !== want.key)
          report_err("min_key", m_axis_tdata[KEY_BITS-1:0], want.key);
        if (m_axis_tdata[KEY_BITS +: WAY_BITS] !== want.way)
          report_err("min_way", KEY_BITS'(m_axis_tdata[KEY_BITS +: WAY_BITS]),
                     KEY_BITS'(want.way));
        if (m_axis_tuser[0] !== want.done)
          report_err("done_res", KEY_BITS'(m_axis_tuser[0]), KEY_BITS'(want.done));
      end
    end
  end

  function automatic logic [KEY_BITS-1:0] pick_key();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return KEY_ONES;
      2: return KEY_BITS'($urandom_range(0, 15));
      3: return KEY_ONES - KEY_BITS'($urandom_range(0, 15));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic void push_item(logic func, logic [KEY_BITS-1:0] key, logic empty);
    way_items_q.push_back('{func: func, empty: empty, key: key});
    items_pushed++;
  endfunction

  // every item taken, every result back, then time for ignored items to settle
  task automatic wait_idle();
    while (items_taken != items_pushed || expected_mins_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLE) @(posedge clk_i);
  endtask

  task automatic write_ways(logic [CNT_BITS-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_WAYS;
    pwdata  <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    ways_cfg = val;
  endtask

  initial begin
    int mode;
    int n_heads;
    int loads;
    int heads_left;
    int i;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // out of range and minimum values; the last one (above the way count) stays
    write_ways(CNT_BITS'(0));
    write_ways(CNT_BITS'(1));
    write_ways(CNT_BITS'(127));

    // 0: fill every way, 1: lower the way count to at most the loaded count,
    // 2: end loading with an empty way
    mode    = $urandom_range(0, 2);
    n_heads = (mode == 0) ? MAX_WAYS : $urandom_range(8, 60);

    push_item(FUNC_REPLACE, KEY_ONES, 1'b0);  // ignored while loading
    push_item(FUNC_LOAD, '0, 1'b0);
    push_item(FUNC_LOAD, KEY_ONES, 1'b0);
    push_item(FUNC_LOAD, {1'b1, {(KEY_BITS-1){1'b0}}}, 1'b0);
    push_item(FUNC_LOAD, KEY_BITS'(1), 1'b0);
    push_item(FUNC_LOAD, KEY_ONES, 1'b0);
    push_item(FUNC_LOAD, '0, 1'b0);
    push_item(FUNC_REPLACE, KEY_BITS'(5), 1'b1);
    loads = 6;
    wait_idle();
    write_ways(CNT_BITS'(MAX_WAYS));

    while (loads < n_heads - 1) begin
      if ($urandom_range(0, 99) < 5) push_item(FUNC_REPLACE, pick_key(), 1'($urandom_range(0, 1)));
      push_item(FUNC_LOAD, pick_key(), 1'b0);
      loads++;
    end
    wait_idle();
    case (mode)
      0: push_item(FUNC_LOAD, pick_key(), 1'b0);
      1: begin
        write_ways(CNT_BITS'($urandom_range(0, n_heads - 1)));
        push_item(FUNC_LOAD, pick_key(), 1'b0);
      end
      default: push_item(FUNC_LOAD, pick_key(), 1'b1);
    endcase
    wait_idle();
    heads_left = n_entries;

    push_item(FUNC_LOAD, KEY_ONES, 1'b1);  // ignored while merging
    push_item(FUNC_REPLACE, '0, 1'b0);
    push_item(FUNC_REPLACE, KEY_ONES, 1'b0);
    push_item(FUNC_REPLACE, KEY_ONES, 1'b0);
    push_item(FUNC_REPLACE, '0, 1'b0);
    push_item(FUNC_REPLACE, pick_key(), 1'b1);
    push_item(FUNC_REPLACE, KEY_BITS'(1), 1'b0);
    heads_left--;

    // spread the exhausted ways so the last one goes no later than the final replace
    for (i = 0; i < MERGE_ITEMS; i++) begin
      if (i == MERGE_ITEMS / 2) begin
        wait_idle();
        write_ways(CNT_BITS'($urandom_range(1, MAX_WAYS)));
      end
      if ($urandom_range(0, 99) < 4) push_item(FUNC_LOAD, pick_key(), 1'($urandom_range(0, 1)));
      if (heads_left > 0 && $urandom_range(0, MERGE_ITEMS - 1 - i) < heads_left) begin
        push_item(FUNC_REPLACE, pick_key(), 1'b1);
        heads_left--;
      end else begin
        push_item(FUNC_REPLACE, pick_key(), 1'b0);
      end
    end

    // replaces and a load after every way is done
    for (i = 0; i < 4; i++) push_item(FUNC_REPLACE, pick_key(), 1'($urandom_range(0, 1)));
    push_item(FUNC_LOAD, pick_key(), 1'b0);
    push_item(FUNC_REPLACE, pick_key(), 1'b0);

    wait_idle();
    if (n_err == 0 && expected_mins_q.size() == 0) begin
      $display("** k_way_heap_merge: PASSED **");
    end else begin
      $display("** k_way_heap_merge: FAILED **");
    end
    $finish;
  end

endmodule
